### rtl/clut_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clut_pkg
// Shared types and constants for the color lookup table interpolator: table
// geometry, payload words, register indexes and control state codes.
// ----------------------------------------------------------------------------
package clut_pkg;

   localparam int GRID_SHIFT   = 4;
   localparam int AXIS_POINTS  = 17;
   localparam int FRAC_BITS    = 8;
   localparam int MAX_IN_DIMS  = 4;
   localparam int MAX_OUT_DIMS = 4;
   localparam int NUM_CHAN     = 4;

   localparam int LUT_DEPTH = (AXIS_POINTS ** MAX_IN_DIMS) * MAX_OUT_DIMS;
   localparam int ADDR_W    = 19;
   localparam int DATA_W    = 16;
   localparam int SAMP_W    = 8;
   localparam int IDX_W     = SAMP_W - GRID_SHIFT;
   localparam int DIM_W     = 3;
   localparam int AXIS_W    = (MAX_IN_DIMS > 1) ? $clog2(MAX_IN_DIMS) : 1;
   localparam int COL_W     = $clog2(NUM_CHAN);
   localparam int K_W       = $clog2(GRID_SHIFT + 1);
   localparam int SUM_W     = DATA_W + GRID_SHIFT + 1;

   localparam int OUT_MAX_NARROW = 255;
   localparam int OUT_MAX_WIDE   = 65535;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_DIMS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_DIMS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDE = 2'd3;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] table_addr;
      logic [DATA_W-1:0] table_data;
      logic [DATA_W-1:0] chan0_in;
      logic [DATA_W-1:0] chan1_in;
      logic [DATA_W-1:0] chan2_in;
      logic [DATA_W-1:0] chan3_in;
   } req_word_type;

   typedef struct packed {
      logic [DATA_W-1:0] chan0_out;
      logic [DATA_W-1:0] chan1_out;
      logic [DATA_W-1:0] chan2_out;
      logic [DATA_W-1:0] chan3_out;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_FLUSH,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### rtl/color_lut_bitplane_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_lut_bitplane_interpolator
// Color lookup table interpolator over a single-port table memory.
// ----------------------------------------------------------------------------
// A write word loads one table entry; writes beyond the table are dropped. A
// convert word holds req_stall high after its acceptance until its result is
// loaded, so the next word is taken only after that: the corner addresses are
// formed one axis per cycle, then one table read per cycle for each output
// channel and each of its 5 corners on the single memory port, then the read
// and rounding stages drain and the result register is loaded, which waits
// while an earlier result is still stalled.
// A finished result waits in its own register, so write words are taken while
// it is stalled. The table has no reset; entries read before written are
// undefined.
// ----------------------------------------------------------------------------
module color_lut_bitplane_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  clut_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output clut_pkg::rsp_word_type              rsp_data,
   input  logic                                csr_we,
   input  logic [clut_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [clut_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int EXT_W  = clut_pkg::SUM_W + 9;
   localparam int SH_N   = clut_pkg::FRAC_BITS + clut_pkg::GRID_SHIFT;
   localparam int SH_W   = clut_pkg::FRAC_BITS + clut_pkg::GRID_SHIFT - 8;
   localparam int SH_W_R = (SH_W > 0) ? SH_W : 0;
   localparam int SH_W_1 = (SH_W > 0) ? SH_W - 1 : 0;
   localparam int SH_W_L = (SH_W > 0) ? 0 : -SH_W;
   localparam int PROD_W = clut_pkg::ADDR_W + clut_pkg::IDX_W;
   localparam int STR_W  = clut_pkg::ADDR_W + 8;

   function automatic logic [clut_pkg::DATA_W-1:0] round_clamp(
      input logic [clut_pkg::SUM_W-1:0] sum,
      input logic                       wide
   );
      logic [EXT_W-1:0] ext_sum;
      logic [EXT_W-1:0] val;
      logic [EXT_W-1:0] omax;
      ext_sum = EXT_W'(sum);
      if (wide) begin
         omax = EXT_W'(clut_pkg::OUT_MAX_WIDE);
         if (SH_W > 0) begin
            val = (ext_sum + (EXT_W'(1) << SH_W_1)) >> SH_W_R;
         end else begin
            val = ext_sum << SH_W_L;
         end
      end else begin
         omax = EXT_W'(clut_pkg::OUT_MAX_NARROW);
         val  = (ext_sum + (EXT_W'(1) << (SH_N - 1))) >> SH_N;
      end
      if (val > omax) begin
         val = omax;
      end
      return val[clut_pkg::DATA_W-1:0];
   endfunction

   // configuration
   logic [clut_pkg::DIM_W-1:0] in_dims_ff, out_dims_ff;
   logic                       in_wide_ff, out_wide_ff;
   logic [clut_pkg::DIM_W-1:0] nin, nout;

   // control
   clut_pkg::state_type        state_ff, state_in;
   logic                       accept, accept_cvt, last_issue, rsp_load;
   logic [clut_pkg::AXIS_W-1:0] axis_cnt_ff;
   logic [clut_pkg::COL_W-1:0] col_cnt_ff;
   logic [clut_pkg::K_W-1:0]   k_cnt_ff;

   // memory port
   logic [clut_pkg::DATA_W-1:0] lut_mem [clut_pkg::LUT_DEPTH];
   logic                        mem_we, mem_re;
   logic [clut_pkg::ADDR_W-1:0] mem_addr;
   logic [clut_pkg::DATA_W-1:0] mem_rdata_ff;

   // corner setup
   logic [clut_pkg::DATA_W-1:0] chan_raw [clut_pkg::NUM_CHAN];
   logic [clut_pkg::SAMP_W-1:0] samp_ff [clut_pkg::MAX_IN_DIMS];
   logic [clut_pkg::ADDR_W-1:0] corner_ff [clut_pkg::GRID_SHIFT+1];
   logic [clut_pkg::ADDR_W-1:0] stride_ff;
   logic [clut_pkg::SAMP_W-1:0] cur_samp;
   logic [clut_pkg::IDX_W-1:0]  idx_raw, idx_lo;
   logic [PROD_W-1:0]           prod;
   logic [STR_W-1:0]            stride_mul;
   logic [clut_pkg::ADDR_W-1:0] lo_off, hi_off;
   logic                        axis_active;

   // accumulate and round
   logic                        tag_valid_ff;
   logic [clut_pkg::K_W-1:0]    tag_k_ff, shamt;
   logic [clut_pkg::COL_W-1:0]  tag_col_ff, fin_col_ff;
   logic [clut_pkg::SUM_W-1:0]  term, acc_ff, fin_sum_ff;
   logic                        fin_valid_ff;
   logic [clut_pkg::DATA_W-1:0] res_ff [clut_pkg::NUM_CHAN];

   logic                        rsp_valid_ff;
   clut_pkg::rsp_word_type      rsp_data_ff;

   always_comb begin
      nin = in_dims_ff;
      if (in_dims_ff == '0) begin
         nin = clut_pkg::DIM_W'(1);
      end else if (in_dims_ff > clut_pkg::DIM_W'(clut_pkg::MAX_IN_DIMS)) begin
         nin = clut_pkg::DIM_W'(clut_pkg::MAX_IN_DIMS);
      end
      nout = out_dims_ff;
      if (out_dims_ff == '0) begin
         nout = clut_pkg::DIM_W'(1);
      end else if (out_dims_ff > clut_pkg::DIM_W'(clut_pkg::MAX_OUT_DIMS)) begin
         nout = clut_pkg::DIM_W'(clut_pkg::MAX_OUT_DIMS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_dims_ff  <= clut_pkg::DIM_W'(3);
         out_dims_ff <= clut_pkg::DIM_W'(3);
         in_wide_ff  <= 1'b0;
         out_wide_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            clut_pkg::CSR_IN_DIMS:  in_dims_ff  <= csr_data;
            clut_pkg::CSR_OUT_DIMS: out_dims_ff <= csr_data;
            clut_pkg::CSR_IN_WIDE:  in_wide_ff  <= csr_data[0];
            clut_pkg::CSR_OUT_WIDE: out_wide_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign accept     = req_valid && !req_stall;
   assign accept_cvt = accept && (req_data.opcode == clut_pkg::OP_CONVERT);
   assign last_issue = (k_cnt_ff == clut_pkg::K_W'(clut_pkg::GRID_SHIFT)) &&
                       ((clut_pkg::DIM_W'(col_cnt_ff) + clut_pkg::DIM_W'(1)) == nout);
   assign rsp_load   = (state_ff == clut_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clut_pkg::ST_IDLE: begin
            if (accept_cvt) state_in = clut_pkg::ST_SETUP;
         end
         clut_pkg::ST_SETUP: begin
            if (axis_cnt_ff == clut_pkg::AXIS_W'(clut_pkg::MAX_IN_DIMS - 1)) begin
               state_in = clut_pkg::ST_READ;
            end
         end
         clut_pkg::ST_READ: begin
            if (last_issue) state_in = clut_pkg::ST_FLUSH;
         end
         clut_pkg::ST_FLUSH: begin
            if (!tag_valid_ff && !fin_valid_ff) state_in = clut_pkg::ST_DONE;
         end
         clut_pkg::ST_DONE: begin
            if (rsp_load) state_in = clut_pkg::ST_IDLE;
         end
         default: state_in = clut_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != clut_pkg::ST_IDLE);
      mem_re    = (state_ff == clut_pkg::ST_READ);
      mem_we    = accept && (req_data.opcode == clut_pkg::OP_WRITE) &&
                  (req_data.table_addr < clut_pkg::ADDR_W'(clut_pkg::LUT_DEPTH));
      if (mem_re) begin
         mem_addr = corner_ff[k_cnt_ff] + clut_pkg::ADDR_W'(col_cnt_ff);
      end else begin
         mem_addr = req_data.table_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clut_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // table memory, single port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lut_mem[mem_addr] <= req_data.table_data;
      end
      if (mem_re) begin
         mem_rdata_ff <= lut_mem[mem_addr];
      end
   end

   // sample reduction and corner offsets
   assign chan_raw[0] = req_data.chan0_in;
   assign chan_raw[1] = req_data.chan1_in;
   assign chan_raw[2] = req_data.chan2_in;
   assign chan_raw[3] = req_data.chan3_in;

   always_comb begin
      cur_samp    = samp_ff[axis_cnt_ff];
      idx_raw     = cur_samp[clut_pkg::SAMP_W-1:clut_pkg::GRID_SHIFT];
      idx_lo      = idx_raw;
      if (int'(idx_raw) > clut_pkg::AXIS_POINTS - 1) begin
         idx_lo = clut_pkg::IDX_W'(clut_pkg::AXIS_POINTS - 1);
      end
      prod        = PROD_W'(idx_lo) * PROD_W'(stride_ff);
      lo_off      = prod[clut_pkg::ADDR_W-1:0];
      hi_off      = lo_off;
      if (int'(idx_lo) < clut_pkg::AXIS_POINTS - 1) begin
         hi_off = lo_off + stride_ff;
      end
      stride_mul  = STR_W'(stride_ff) * STR_W'(clut_pkg::AXIS_POINTS);
      axis_active = (clut_pkg::DIM_W'(axis_cnt_ff) < nin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_cnt_ff <= '0;
         col_cnt_ff  <= '0;
         k_cnt_ff    <= '0;
      end else if (accept_cvt) begin
         axis_cnt_ff <= '0;
         col_cnt_ff  <= '0;
         k_cnt_ff    <= '0;
      end else if (state_ff == clut_pkg::ST_SETUP) begin
         axis_cnt_ff <= axis_cnt_ff + clut_pkg::AXIS_W'(1);
      end else if (state_ff == clut_pkg::ST_READ) begin
         if (k_cnt_ff == clut_pkg::K_W'(clut_pkg::GRID_SHIFT)) begin
            k_cnt_ff   <= '0;
            col_cnt_ff <= col_cnt_ff + clut_pkg::COL_W'(1);
         end else begin
            k_cnt_ff <= k_cnt_ff + clut_pkg::K_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_cvt) begin
         for (int a = 0; a < clut_pkg::MAX_IN_DIMS; a++) begin
            samp_ff[a] <= in_wide_ff ? chan_raw[a][15:8] : chan_raw[a][7:0];
         end
         for (int k = 0; k <= clut_pkg::GRID_SHIFT; k++) begin
            corner_ff[k] <= '0;
         end
         stride_ff <= clut_pkg::ADDR_W'(nout);
      end else if ((state_ff == clut_pkg::ST_SETUP) && axis_active) begin
         corner_ff[0] <= corner_ff[0] + lo_off;
         for (int k = 1; k <= clut_pkg::GRID_SHIFT; k++) begin
            corner_ff[k] <= corner_ff[k] + (cur_samp[k-1] ? hi_off : lo_off);
         end
         stride_ff <= stride_mul[clut_pkg::ADDR_W-1:0];
      end
   end

   // read tags, accumulation, rounding
   assign shamt = (tag_k_ff == '0) ? '0 : tag_k_ff - clut_pkg::K_W'(1);
   assign term  = clut_pkg::SUM_W'(mem_rdata_ff) << shamt;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         tag_valid_ff <= mem_re;
         fin_valid_ff <= tag_valid_ff &&
                         (tag_k_ff == clut_pkg::K_W'(clut_pkg::GRID_SHIFT));
      end
   end

   always_ff @(posedge clock) begin
      tag_k_ff   <= k_cnt_ff;
      tag_col_ff <= col_cnt_ff;
      fin_col_ff <= tag_col_ff;
      fin_sum_ff <= acc_ff + term;
      if (tag_valid_ff) begin
         if (tag_k_ff == '0) begin
            acc_ff <= term;
         end else begin
            acc_ff <= acc_ff + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_cvt) begin
         for (int c = 0; c < clut_pkg::NUM_CHAN; c++) begin
            res_ff[c] <= '0;
         end
      end else if (fin_valid_ff) begin
         res_ff[fin_col_ff] <= round_clamp(fin_sum_ff, out_wide_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.chan0_out <= res_ff[0];
         rsp_data_ff.chan1_out <= res_ff[1];
         rsp_data_ff.chan2_out <= res_ff[2];
         rsp_data_ff.chan3_out <= res_ff[3];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == clut_pkg::ST_IDLE))
      else $error("table write outside idle");

   a_tag_from_read: assert property (@(posedge clock) disable iff (reset)
      tag_valid_ff |-> ($past(state_ff) == clut_pkg::ST_READ))
      else $error("read data without a read");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clut_pkg::ST_DONE) |-> (!tag_valid_ff && !fin_valid_ff))
      else $error("result loaded before pipeline drained");

   a_fin_col_range: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff |-> (clut_pkg::DIM_W'(fin_col_ff) < nout))
      else $error("finished column beyond out_dims");

endmodule
`default_nettype wire
